// File: sv/mrgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrgs_pkg: shared types for the merge sorter
// Holds the data word type and the control bundle broadcast to every sort cell.
// ----------------------------------------------------------------------------
package mrgs_pkg;

	localparam int unsigned WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	// Broadcast control for the cell chain
	typedef struct packed {
		logic  insert;  // place x into the sorted chain
		logic  pop;     // shift the chain toward the head by one
		word_t x;       // incoming item value
	} cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/merge_sorter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sorter_top: streaming sorter for sets of signed 32-bit values
// Collects a set terminated by tlast and replays it in ascending order.
// ----------------------------------------------------------------------------
// Items of a set are taken one per cycle and inserted into a chain of
// MAX_COUNT sort cells, which keeps the set ordered as it arrives. After the
// item with tlast, the chain shifts toward its head one slot per cycle while
// the sink is ready and streams the set out smallest first, one result per
// cycle, with tlast on the largest value. The next set is taken from the
// cycle after its last result enters the output register. Items past
// MAX_COUNT in a set are dropped, and every result of that set carries
// tuser (dropped) high.
// ----------------------------------------------------------------------------
module merge_sorter_top #(
	parameter int unsigned MAX_COUNT = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input items
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // [31:0] value
	input  wire         s_axis_tlast,   // final_req
	// Result items
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
	output logic        m_axis_tlast,   // end_of_run
	output logic        m_axis_tuser    // [0] dropped
);

	localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COUNT);

	localparam logic PH_LOAD = 1'b0;
	localparam logic PH_EMIT = 1'b1;

	logic             phase_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             drop_q;
	logic             out_vld_q;
	mrgs_pkg::word_t  out_val_q;
	logic             out_last_q;
	logic             out_drop_q;

	logic             accept;
	logic             full;
	logic             pop;
	logic             last_pop;

	mrgs_pkg::cell_ctrl_t ctrl;
	mrgs_pkg::word_t      cval [MAX_COUNT];
	logic [MAX_COUNT-1:0] cvld;
	logic [MAX_COUNT-1:0] cgt;

	// Handshake and chain control
	assign s_axis_tready = (phase_q == PH_LOAD);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q == MAX_CNT);
	assign pop           = (phase_q == PH_EMIT) && (!out_vld_q || m_axis_tready);
	assign last_pop      = pop && !cvld[1];

	assign ctrl.insert = accept && !full;
	assign ctrl.pop    = pop;
	assign ctrl.x      = mrgs_pkg::word_t'(s_axis_tdata);

	// Cell chain: head is the smallest value
	for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
		mrgs_pkg::word_t l_val;
		logic            l_vld;
		logic            l_gt;
		mrgs_pkg::word_t r_val;
		logic            r_vld;

		if (i == 0) begin : g_head
			assign l_val = ctrl.x;
			assign l_vld = 1'b1;
			assign l_gt  = 1'b1;
		end else begin : g_body
			assign l_val = cval[i-1];
			assign l_vld = cvld[i-1];
			assign l_gt  = cgt[i-1];
		end

		if (i == MAX_COUNT - 1) begin : g_tail
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_mid
			assign r_val = cval[i+1];
			assign r_vld = cvld[i+1];
		end

		mrgs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_val  (l_val),
			.left_vld  (l_vld),
			.left_gt   (l_gt),
			.right_val (r_val),
			.right_vld (r_vld),
			.val       (cval[i]),
			.vld       (cvld[i]),
			.gt        (cgt[i])
		);
	end

	// Phase, fill count and overflow tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LOAD;
			count_q    <= '0;
			overflow_q <= 1'b0;
			drop_q     <= 1'b0;
		end else begin
			if (accept) begin
				if (s_axis_tlast) begin
					phase_q    <= PH_EMIT;
					count_q    <= '0;
					overflow_q <= 1'b0;
					drop_q     <= overflow_q || full;
				end else if (full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (last_pop) begin
				phase_q <= PH_LOAD;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pop) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_val_q  <= cval[0];
			out_last_q <= !cvld[1];
			out_drop_q <= drop_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_drop_q;

`ifndef SYNTHESIS
	// Occupied cells always form an unbroken run from the head
	assert property (@(posedge clk) disable iff (!arst_n)
		((cvld >> 1) & ~cvld) == '0)
		else $error("cell chain has a gap");

	// While loading, the occupied cells match the fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LOAD) |-> ($countones(cvld) == int'(count_q)))
		else $error("fill count out of step with cell chain");

	// A set being emitted is never empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EMIT) |-> cvld[0])
		else $error("emitting from an empty chain");

	// The largest value leaves the chain last, flagged as end of run
	assert property (@(posedge clk) disable iff (!arst_n)
		last_pop |=> (m_axis_tvalid && m_axis_tlast && (phase_q == PH_LOAD)
			&& (cvld == '0)))
		else $error("end of run out of step with chain drain");
`endif

endmodule
`default_nettype wire

// File: sv/mrgs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrgs_cell: one slot of the systolic insertion sorter
// Holds one value and a valid bit. On insert it keeps its value, takes the
// incoming item, or takes its left neighbor's value; on pop it takes its
// right neighbor's value.
// ----------------------------------------------------------------------------
module mrgs_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire mrgs_pkg::cell_ctrl_t ctrl,
	input  wire mrgs_pkg::word_t      left_val,
	input  wire                       left_vld,
	input  wire                       left_gt,
	input  wire mrgs_pkg::word_t      right_val,
	input  wire                       right_vld,
	output mrgs_pkg::word_t           val,
	output logic                      vld,
	output logic                      gt
);

	mrgs_pkg::word_t val_q;
	logic            vld_q;

	// Empty slot or larger value: the incoming item goes at or before this slot
	assign gt  = !vld_q || (val_q > ctrl.x);
	assign val = val_q;
	assign vld = vld_q;

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.pop) begin
			vld_q <= right_vld;
		end else if (ctrl.insert && gt) begin
			vld_q <= left_gt ? left_vld : 1'b1;
		end
	end

	// Value
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			val_q <= right_val;
		end else if (ctrl.insert && gt) begin
			val_q <= left_gt ? left_val : ctrl.x;
		end
	end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for merge_sorter_top
// Streams sets of signed words into the sorter with random gaps on both sides
// and checks every result against an in-bench sort of the same set,
// including sets that overflow the store and sets of a single item.
// ----------------------------------------------------------------------------
module testbench;

	typedef mrgs_pkg::word_t word_t;

	localparam int unsigned CAPACITY       = 32;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned TAIL_CYCLES    = 64;
	localparam int unsigned TARGET_ITEMS   = 500;
	localparam int unsigned MAX_REPORTS    = 20;

	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7FFF_FFFF;

	// One input item waiting to be sent
	typedef struct {
		word_t value;
		logic  fin;
	} send_item_t;

	// One result item expected from the sorter
	typedef struct {
		word_t value;
		logic  last;
		logic  dropped;
	} sorted_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // [31:0] value
	logic        s_axis_tlast = 1'b0; // final_req
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // [31:0] sorted_value
	logic        m_axis_tlast;        // end_of_run
	logic        m_axis_tuser;        // [0] dropped

	send_item_t   send_q[$];
	sorted_item_t sorted_q[$];
	word_t        held_vals[$];
	logic         held_overflow = 1'b0;

	int unsigned src_gap = 0;
	int unsigned sink_gap = 0;
	int unsigned quiet_cycles = 0;
	int unsigned cyc_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned items_in = 0;
	int unsigned results_seen = 0;
	int unsigned sets_done = 0;
	int unsigned sets_overflowed = 0;

	send_item_t next_item;

	merge_sorter_top #(
		.MAX_COUNT(CAPACITY)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones; no gaps in one stretch out of eight
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (cyc_cnt[8:6] == 3'd0) return 0;
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_cnt < MAX_REPORTS)
			$display("mismatch @%0d: %s", cyc_cnt, msg);
		err_cnt++;
	endtask

	// Values: full range, a narrow band for duplicates, or the corner words
	function automatic word_t rand_word();
		int unsigned mode;
		mode = $urandom_range(0, 9);
		if (mode < 5) return word_t'($urandom);
		if (mode < 8) return word_t'($urandom_range(0, 16)) - 8;
		case ($urandom_range(0, 5))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return WORD_MIN + 1;
			3: return WORD_MAX - 1;
			4: return '0;
			default: return -1;
		endcase
	endfunction

	task automatic queue_set(input word_t vals[$]);
		send_item_t it;
		foreach (vals[i]) begin
			it.value = vals[i];
			it.fin   = (i == vals.size() - 1);
			send_q.push_back(it);
		end
	endtask

	// Sort the held set ascending and queue it as expected results
	task automatic emit_sorted();
		word_t        key;
		int           p;
		sorted_item_t res;
		for (int k = 1; k < held_vals.size(); k++) begin
			key = held_vals[k];
			p = k;
			while (p > 0 && held_vals[p-1] > key) begin
				held_vals[p] = held_vals[p-1];
				p--;
			end
			held_vals[p] = key;
		end
		foreach (held_vals[i]) begin
			res.value   = held_vals[i];
			res.last    = (i == held_vals.size() - 1);
			res.dropped = held_overflow;
			sorted_q.push_back(res);
		end
		sets_done++;
		if (held_overflow) sets_overflowed++;
		held_vals.delete();
		held_overflow = 1'b0;
	endtask

	// Collect an accepted value; values past capacity are dropped
	task automatic take_value(input word_t v, input logic fin);
		items_in++;
		if (held_vals.size() < CAPACITY)
			held_vals.push_back(v);
		else
			held_overflow = 1'b1;
		if (fin) emit_sorted();
	endtask

	task automatic check_result();
		sorted_item_t want;
		results_seen++;
		if (sorted_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result %0d", $signed(m_axis_tdata)));
		end else begin
			want = sorted_q.pop_front();
			if (word_t'(m_axis_tdata) !== want.value)
				report_mismatch($sformatf("value %0d, expected %0d",
					$signed(m_axis_tdata), want.value));
			if (m_axis_tlast !== want.last)
				report_mismatch($sformatf("end_of_run %b, expected %b",
					m_axis_tlast, want.last));
			if (m_axis_tuser !== want.dropped)
				report_mismatch($sformatf("dropped %b, expected %b",
					m_axis_tuser, want.dropped));
		end
	endtask

	// Driver: present the next pending item once the current one is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (send_q.size() != 0) begin
				next_item = send_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= next_item.value;
				s_axis_tlast <= next_item.fin;
				src_gap <= pick_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Sink: random back-pressure on the result side
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap <= 0;
		end else if (sink_gap != 0) begin
			sink_gap <= sink_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			sink_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
		end
	end

	// Monitor: predict on accepted inputs, then check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				take_value(word_t'(s_axis_tdata), s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and end of run
	initial begin
		word_t       vals[$];
		int unsigned queued;
		int unsigned len;
		int unsigned r;

		// Directed: single item, corner words, duplicates, sorted and reversed
		queue_set('{word_t'(0)});
		queue_set('{WORD_MAX, WORD_MIN, word_t'(-1), word_t'(0), word_t'(1)});
		queue_set('{word_t'(7), word_t'(-7), word_t'(7), word_t'(7)});
		queue_set('{word_t'(-3), word_t'(-2), word_t'(-1), word_t'(0), word_t'(1), word_t'(2)});
		queue_set('{WORD_MAX, word_t'(100), word_t'(-100), WORD_MIN});
		queue_set('{word_t'(32'h5555_5555), word_t'(32'hAAAA_AAAA)});
		queued = send_q.size();

		// Random sets: mostly short, some around capacity to fill and overflow
		while (queued < TARGET_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 12) len = $urandom_range(CAPACITY - 2, CAPACITY + 6);
			else if (r < 18) len = 1;
			else len = $urandom_range(2, 12);
			vals.delete();
			repeat (len) vals.push_back(rand_word());
			queue_set(vals);
			queued += len;
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (send_q.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sorted_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", sorted_q.size()));
		$display("sent %0d items in %0d sets (%0d overflowed), checked %0d results",
			items_in, sets_done, sets_overflowed, results_seen);
		$display("mismatches: %0d", err_cnt);
		if (err_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
sv/mrgs_pkg.sv
sv/mrgs_cell.sv
sv/merge_sorter_top.sv
tb/sv/testbench.sv
